/* hdl/decimal_float_text_parser_unit_macros.svh */
// ============================================================================
// Assertion macros for the decimal text parser
// Short forms for clocked assertions that are disabled while reset is held.
// ============================================================================
`ifndef DECIMAL_FLOAT_TEXT_PARSER_UNIT_MACROS_SVH
`define DECIMAL_FLOAT_TEXT_PARSER_UNIT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define DFTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Trigger at one edge implies the expression at the next edge.
`define DFTP_ASSERT_NEXT(lbl, trig, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
    else $error(msg);

`endif

/* hdl/dftp_pkg.sv */
// ============================================================================
// Decimal text parser package
// Shared constants, character classes, phase codes, the token and record
// types, and the final exponent combine.
// ============================================================================
package dftp_pkg;

  // Default exponent saturation limit and queue depth.
  localparam int unsigned EXP_LIMIT_DEF   = 9999;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Field widths.
  localparam int unsigned MANT_W  = 64;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned EXP_W   = 14;

  // Character codes.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;

  // Character classes produced by the front end.
  typedef logic [2:0] cls_t;
  localparam cls_t CLS_DIGIT = 3'd0;
  localparam cls_t CLS_BLANK = 3'd1;
  localparam cls_t CLS_MINUS = 3'd2;
  localparam cls_t CLS_PLUS  = 3'd3;
  localparam cls_t CLS_POINT = 3'd4;
  localparam cls_t CLS_EXP   = 3'd5;
  localparam cls_t CLS_OTHER = 3'd6;

  // Parse phases of the back end.
  typedef logic [2:0] phase_t;
  localparam phase_t PH_BLANK = 3'd0;
  localparam phase_t PH_INT   = 3'd1;
  localparam phase_t PH_FRAC  = 3'd2;
  localparam phase_t PH_ESIGN = 3'd3;
  localparam phase_t PH_EDIG  = 3'd4;
  localparam phase_t PH_DONE  = 3'd5;

  // One classified character.
  typedef struct packed {
    cls_t       cls;
    logic [3:0] digit;
    logic       last;
  } tok_t;

  // Parse state, also the raw form of one finished result.
  typedef struct packed {
    logic                      negative;
    logic [MANT_W-1:0]         mantissa;
    logic signed [SCALE_W-1:0] scale;
    logic [EXP_W-1:0]          exp_mag;
    logic                      exp_neg;
    logic                      dropped;
    logic                      saturated;
  } rec_t;

  // Final decimal exponent and its clamp flag.
  typedef struct packed {
    logic signed [SCALE_W-1:0] value;
    logic                      clamped;
  } fin_t;

  // Combine the scale with the signed exponent value and saturate to 16 bits.
  function automatic fin_t finish_exp(input rec_t r);
    logic signed [SCALE_W:0] mag;
    logic signed [SCALE_W:0] sum;
    fin_t                    f;
    mag = signed'({{(SCALE_W + 1 - EXP_W){1'b0}}, r.exp_mag});
    sum = signed'({r.scale[SCALE_W-1], r.scale}) + (r.exp_neg ? -mag : mag);
    f.clamped = r.saturated;
    if (sum > 17'sd32767) begin
      f.value   = 16'sh7FFF;
      f.clamped = 1'b1;
    end else if (sum < -17'sd32768) begin
      f.value   = 16'sh8000;
      f.clamped = 1'b1;
    end else begin
      f.value = sum[SCALE_W-1:0];
    end
    return f;
  endfunction

endpackage

/* hdl/dftp_fifo.sv */
// ============================================================================
// Small register queue
// Fixed-depth queue of flip-flops with push/full and pop/empty sides; the
// head entry is always presented on rdata.
// ============================================================================
module dftp_fifo #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Pointer and count updates with wrap at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* hdl/dftp_front.sv */
// ============================================================================
// Decimal text parser front end
// Accepts one character per beat, classifies it and queues the token for
// the parse engine.
// ============================================================================
module dftp_front #(
  parameter int unsigned QUEUE_DEPTH = dftp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         in_char_code,
  input  logic               in_end_of_text,
  input  logic               push,
  output logic               full,
  input  logic               tok_pop,
  output dftp_pkg::tok_t     tok,
  output logic               tok_empty
);

  dftp_pkg::tok_t tok_in;
  logic [7:0]     digit_val;

  assign digit_val = in_char_code - dftp_pkg::CH_ZERO;

  // Character classifier.
  always_comb begin
    tok_in.digit = digit_val[3:0];
    tok_in.last  = in_end_of_text;
    if (in_char_code >= dftp_pkg::CH_ZERO && in_char_code <= dftp_pkg::CH_NINE) begin
      tok_in.cls = dftp_pkg::CLS_DIGIT;
    end else if (in_char_code == dftp_pkg::CH_SPACE || in_char_code == dftp_pkg::CH_TAB) begin
      tok_in.cls = dftp_pkg::CLS_BLANK;
    end else if (in_char_code == dftp_pkg::CH_MINUS) begin
      tok_in.cls = dftp_pkg::CLS_MINUS;
    end else if (in_char_code == dftp_pkg::CH_PLUS) begin
      tok_in.cls = dftp_pkg::CLS_PLUS;
    end else if (in_char_code == dftp_pkg::CH_POINT) begin
      tok_in.cls = dftp_pkg::CLS_POINT;
    end else if (in_char_code == dftp_pkg::CH_E_LO || in_char_code == dftp_pkg::CH_E_UP) begin
      tok_in.cls = dftp_pkg::CLS_EXP;
    end else begin
      tok_in.cls = dftp_pkg::CLS_OTHER;
    end
  end

  // Token queue between the front end and the parse engine.
  dftp_fifo #(
    .WIDTH ($bits(dftp_pkg::tok_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_tok_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (tok_in),
    .full  (full),
    .pop   (tok_pop),
    .rdata (tok),
    .empty (tok_empty)
  );

endmodule

/* hdl/dftp_back.sv */
// ============================================================================
// Decimal text parser engine
// Steps the parse FSM one token per cycle (the last token waits for result room),
// accumulates mantissa, scale and exponent, emits the state as a record on it.
// ============================================================================
module dftp_back #(
  parameter int unsigned EXP_LIMIT = dftp_pkg::EXP_LIMIT_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  dftp_pkg::tok_t tok,
  input  logic           tok_empty,
  output logic           tok_pop,
  input  logic           res_full,
  output logic           res_push,
  output dftp_pkg::rec_t res
);

  localparam int unsigned MW = dftp_pkg::MANT_W;
  localparam int unsigned EW = dftp_pkg::EXP_W;
  localparam logic [EW-1:0] LIMIT_E = EW'(EXP_LIMIT);
  localparam logic [EW+3:0] LIMIT_X = (EW + 4)'(EXP_LIMIT);

  dftp_pkg::rec_t   rec_r, rec_nxt;
  dftp_pkg::phase_t phase_r, phase_nxt;
  logic             take_int, take_frac, take_exp;
  logic [MW+3:0]    mant_prod;
  logic [EW+3:0]    exp_prod;
  logic             mant_fits;

  // A token moves when no result is pending or the result queue has room.
  assign tok_pop  = !tok_empty && (!tok.last || !res_full);
  assign res_push = tok_pop && tok.last;
  assign res      = rec_nxt;

  // Times ten plus digit, kept wide to see the carry out.
  assign mant_prod = ({4'b0000, rec_r.mantissa} << 3) + ({4'b0000, rec_r.mantissa} << 1)
                   + {{MW{1'b0}}, tok.digit};
  assign mant_fits = !rec_r.dropped && (mant_prod[MW+3:MW] == 4'b0000);
  assign exp_prod  = ({4'b0000, rec_r.exp_mag} << 3) + ({4'b0000, rec_r.exp_mag} << 1)
                   + {{EW{1'b0}}, tok.digit};

  // Phase transitions and decode of the token into update actions.
  always_comb begin
    phase_nxt = phase_r;
    take_int  = 1'b0;
    take_frac = 1'b0;
    take_exp  = 1'b0;
    rec_nxt   = rec_r;
    unique case (phase_r)
      dftp_pkg::PH_BLANK: begin
        unique case (tok.cls)
          dftp_pkg::CLS_BLANK: phase_nxt = dftp_pkg::PH_BLANK;
          dftp_pkg::CLS_MINUS: begin
            rec_nxt.negative = 1'b1;
            phase_nxt        = dftp_pkg::PH_INT;
          end
          dftp_pkg::CLS_PLUS: phase_nxt = dftp_pkg::PH_INT;
          dftp_pkg::CLS_DIGIT: begin
            take_int  = 1'b1;
            phase_nxt = dftp_pkg::PH_INT;
          end
          dftp_pkg::CLS_POINT: phase_nxt = dftp_pkg::PH_FRAC;
          dftp_pkg::CLS_EXP:   phase_nxt = dftp_pkg::PH_ESIGN;
          default:             phase_nxt = dftp_pkg::PH_DONE;
        endcase
      end
      dftp_pkg::PH_INT: begin
        unique case (tok.cls)
          dftp_pkg::CLS_DIGIT: take_int  = 1'b1;
          dftp_pkg::CLS_POINT: phase_nxt = dftp_pkg::PH_FRAC;
          dftp_pkg::CLS_EXP:   phase_nxt = dftp_pkg::PH_ESIGN;
          default:             phase_nxt = dftp_pkg::PH_DONE;
        endcase
      end
      dftp_pkg::PH_FRAC: begin
        unique case (tok.cls)
          dftp_pkg::CLS_DIGIT: take_frac = 1'b1;
          dftp_pkg::CLS_EXP:   phase_nxt = dftp_pkg::PH_ESIGN;
          default:             phase_nxt = dftp_pkg::PH_DONE;
        endcase
      end
      dftp_pkg::PH_ESIGN: begin
        unique case (tok.cls)
          dftp_pkg::CLS_MINUS: begin
            rec_nxt.exp_neg = 1'b1;
            phase_nxt       = dftp_pkg::PH_EDIG;
          end
          dftp_pkg::CLS_PLUS: phase_nxt = dftp_pkg::PH_EDIG;
          dftp_pkg::CLS_DIGIT: begin
            take_exp  = 1'b1;
            phase_nxt = dftp_pkg::PH_EDIG;
          end
          default: phase_nxt = dftp_pkg::PH_DONE;
        endcase
      end
      dftp_pkg::PH_EDIG: begin
        unique case (tok.cls)
          dftp_pkg::CLS_DIGIT: take_exp  = 1'b1;
          default:             phase_nxt = dftp_pkg::PH_DONE;
        endcase
      end
      default: phase_nxt = dftp_pkg::PH_DONE;
    endcase

    // Mantissa digit: keep it while it fits, otherwise drop it and track scale.
    if (take_int || take_frac) begin
      if (mant_fits) begin
        rec_nxt.mantissa = mant_prod[MW-1:0];
        if (take_frac) begin
          if (rec_r.scale == 16'sh8000) begin
            rec_nxt.saturated = 1'b1;
          end else begin
            rec_nxt.scale = rec_r.scale - 16'sd1;
          end
        end
      end else begin
        rec_nxt.dropped = 1'b1;
        if (take_int) begin
          if (rec_r.scale == 16'sh7FFF) begin
            rec_nxt.saturated = 1'b1;
          end else begin
            rec_nxt.scale = rec_r.scale + 16'sd1;
          end
        end
      end
    end

    // Exponent digit with saturation at the limit.
    if (take_exp) begin
      if (exp_prod > LIMIT_X) begin
        rec_nxt.exp_mag   = LIMIT_E;
        rec_nxt.saturated = 1'b1;
      end else begin
        rec_nxt.exp_mag = exp_prod[EW-1:0];
      end
    end
  end

  // Parse state; the last token of a string returns it to the start.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dftp_pkg::PH_BLANK;
      rec_r   <= '0;
    end else if (tok_pop) begin
      if (tok.last) begin
        phase_r <= dftp_pkg::PH_BLANK;
        rec_r   <= '0;
      end else begin
        phase_r <= phase_nxt;
        rec_r   <= rec_nxt;
      end
    end
  end

endmodule

/* hdl/decimal_float_text_parser_unit.sv */
// ============================================================================
// Decimal text parser unit
// Turns a character stream into sign, 64-bit decimal mantissa and exponent.
// ============================================================================
// Usage:
//   Input side is a queue: drive one character and its end_of_text mark with
//   push; the beat is taken when full is low. The character marked end of
//   text closes the string and yields exactly one result; other characters
//   yield none.
//   Result side is a queue: while empty is low the oldest result sits on the
//   out_ ports; pop with empty low takes it.
//   A closing character's result passes through the token queue, then the
//   parse engine into the result queue.
//   Throughput: one character per cycle while the result queue has room, set by
//   the parse engine, which handles one token per cycle with a
//   times-ten-plus-digit add on the mantissa.
//   If the result queue fills because pop stays low, the engine holds the
//   closing token, the token queue fills and full rises; nothing is lost.
//   Reset (rst_n low, synchronous) empties both queues and returns the parse
//   to the leading-blank phase.
// ============================================================================
module decimal_float_text_parser_unit #(
  parameter int unsigned EXP_LIMIT   = dftp_pkg::EXP_LIMIT_DEF,
  parameter int unsigned QUEUE_DEPTH = dftp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         in_char_code,
  input  logic               in_end_of_text,
  input  logic               push,
  output logic               full,
  output logic               out_negative,
  output logic [63:0]        out_mantissa,
  output logic signed [15:0] out_decimal_exponent,
  output logic               out_inexact,
  output logic               out_exponent_clamped,
  output logic               empty,
  input  logic               pop
);

  dftp_pkg::tok_t tok;
  logic           tok_empty;
  logic           tok_pop;
  dftp_pkg::rec_t res_in;
  dftp_pkg::rec_t res_head;
  logic           res_push;
  logic           res_full;
  dftp_pkg::fin_t fin;

  // Front end: classify and queue characters.
  dftp_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_char_code   (in_char_code),
    .in_end_of_text (in_end_of_text),
    .push           (push),
    .full           (full),
    .tok_pop        (tok_pop),
    .tok            (tok),
    .tok_empty      (tok_empty)
  );

  // Parse engine.
  dftp_back #(
    .EXP_LIMIT (EXP_LIMIT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok       (tok),
    .tok_empty (tok_empty),
    .tok_pop   (tok_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // Result queue holding raw records.
  dftp_fifo #(
    .WIDTH ($bits(dftp_pkg::rec_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_head),
    .empty (empty)
  );

  // Final exponent combine on the head record.
  assign fin                  = dftp_pkg::finish_exp(res_head);
  assign out_negative         = res_head.negative;
  assign out_mantissa         = res_head.mantissa;
  assign out_decimal_exponent = fin.value;
  assign out_inexact          = res_head.dropped;
  assign out_exponent_clamped = fin.clamped;

endmodule

/* hdl/dftp_checker.sv */
// ============================================================================
// Decimal text parser port checker
// Watches the top-level ports for result hold, mantissa and flow rules.
// ============================================================================
`include "decimal_float_text_parser_unit_macros.svh"

module dftp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic [63:0]        out_mantissa,
  input logic signed [15:0] out_decimal_exponent,
  input logic               out_inexact
);

  // A waiting result that is not taken stays and keeps its value.
  `DFTP_ASSERT_NEXT(a_res_hold, !empty && !pop, !empty && $stable(out_mantissa) && $stable(out_decimal_exponent), "result changed while stalled")

  // Dropped digits happen only with a mantissa too large to take another digit.
  `DFTP_ASSERT(a_inexact_full, (!empty && out_inexact) |-> (out_mantissa >= 64'h1999999999999999), "inexact with a small mantissa")

  // The input queue only becomes full right after an accepted beat.
  `DFTP_ASSERT(a_full_after_push, $rose(full) |-> $past(push && !full), "full rose without a beat")

endmodule

bind decimal_float_text_parser_unit dftp_checker u_dftp_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .push                 (push),
  .full                 (full),
  .empty                (empty),
  .pop                  (pop),
  .out_mantissa         (out_mantissa),
  .out_decimal_exponent (out_decimal_exponent),
  .out_inexact          (out_inexact)
);
